FILE: sv/acc_pkg.sv
// Shared types and constants for the alarm clock controller.
package acc_pkg;

    // request kinds
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_CHAR = 1'b1;

    // configuration register indexes
    localparam int   CFG_IDX_W     = 1;
    localparam logic CFG_IDX_TPS   = 1'b0;
    localparam logic CFG_IDX_DEB   = 1'b1;
    localparam int   CFG_DATA_W    = 16;
    localparam logic [CFG_DATA_W-1:0] TPS_RESET = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] DEB_RESET = 16'd50;

    // digit buffer
    localparam int   MAX_DIGITS   = 8;
    localparam int   DIGIT_IDX_W  = 3;
    localparam int   DIGIT_CNT_W  = 4;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // time limits
    localparam logic [5:0] SECONDS_MAX = 6'd59;
    localparam logic [5:0] MINUTES_MAX = 6'd59;
    localparam logic [4:0] HOURS_MAX   = 5'd23;
    localparam logic [4:0] NOON_HOUR   = 5'd12;

    localparam int DISPLAY_W = 11;
    localparam int ALARM_W   = 14;

    // values committed from the serial buffer
    typedef struct packed {
        logic               valid;
        logic [4:0]         hours;
        logic [5:0]         minutes;
        logic [ALARM_W-1:0] alarm_time;
    } t_commit;

    // shown time after the current request
    typedef struct packed {
        logic [DISPLAY_W-1:0] display_value;
        logic                 colon_on;
        logic                 is_pm;
    } t_view;

endpackage

FILE: sv/acc_req_if.sv
// Request channel: tick or serial character with samples.
interface acc_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic       button_level;
    logic [9:0] pot_level;
    logic [7:0] serial_char;

    modport source (output valid, cmd, button_level, pot_level, serial_char, input ready);
    modport sink   (input valid, cmd, button_level, pot_level, serial_char, output ready);
endinterface

FILE: sv/acc_rsp_if.sv
// Result channel: display time, colon, PM flag, alarm and buzzer.
interface acc_rsp_if;
    logic        valid;
    logic        ready;
    logic [10:0] display_value;
    logic        colon_on;
    logic        is_pm;
    logic        alarm_active;
    logic [7:0]  buzzer_level;

    modport source (output valid, display_value, colon_on, is_pm, alarm_active, buzzer_level,
                    input ready);
    modport sink   (input valid, display_value, colon_on, is_pm, alarm_active, buzzer_level,
                    output ready);
endinterface

FILE: sv/acc_serial.sv
// Serial digit buffer and commit of hour, minute and alarm values.
module acc_serial (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_cmd,
    input  logic [7:0]       i_char,
    output acc_pkg::t_commit o_commit
);
    import acc_pkg::*;

    logic [3:0]             r_digits [MAX_DIGITS];
    logic [DIGIT_CNT_W-1:0] r_count;
    logic [DIGIT_CNT_W-1:0] n_count;
    logic                   is_char;
    logic                   is_digit;
    logic                   do_store;
    logic [6:0]             h_grp;
    logic [6:0]             m_grp;
    logic [ALARM_W-1:0]     a_grp;

    assign is_char  = i_fire && (i_cmd == CMD_CHAR);
    assign is_digit = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
    assign do_store = is_char && is_digit && (r_count < DIGIT_CNT_W'(MAX_DIGITS));

    always_comb begin
        n_count = r_count;
        if (is_char) begin
            if (do_store) begin
                n_count = r_count + 1'b1;
            end else begin
                // ninth digit or terminator: empty the buffer
                n_count = '0;
            end
        end
    end

    // only digits below the count take part in a group
    always_comb begin
        if (r_count >= 4'd2) begin
            h_grp = 7'(r_digits[0]) * 7'd10 + 7'(r_digits[1]);
        end else if (r_count == 4'd1) begin
            h_grp = 7'(r_digits[0]);
        end else begin
            h_grp = '0;
        end

        if (r_count >= 4'd4) begin
            m_grp = 7'(r_digits[2]) * 7'd10 + 7'(r_digits[3]);
        end else if (r_count == 4'd3) begin
            m_grp = 7'(r_digits[2]);
        end else begin
            m_grp = '0;
        end

        case (r_count)
            4'd5:    a_grp = ALARM_W'(r_digits[4]);
            4'd6:    a_grp = ALARM_W'(r_digits[4]) * 14'd10 + ALARM_W'(r_digits[5]);
            4'd7:    a_grp = ALARM_W'(r_digits[4]) * 14'd100
                           + ALARM_W'(r_digits[5]) * 14'd10 + ALARM_W'(r_digits[6]);
            4'd8:    a_grp = ALARM_W'(r_digits[4]) * 14'd1000
                           + ALARM_W'(r_digits[5]) * 14'd100
                           + ALARM_W'(r_digits[6]) * 14'd10 + ALARM_W'(r_digits[7]);
            default: a_grp = '0;
        endcase
    end

    always_comb begin
        o_commit.valid      = is_char && !is_digit;
        o_commit.hours      = (h_grp > 7'(HOURS_MAX)) ? HOURS_MAX : h_grp[4:0];
        o_commit.minutes    = (m_grp > 7'(MINUTES_MAX)) ? MINUTES_MAX : m_grp[5:0];
        o_commit.alarm_time = a_grp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_digits[r_count[DIGIT_IDX_W-1:0]] <= i_char[3:0];
        end
    end

endmodule

FILE: sv/acc_timekeep.sv
// Tick counter, seconds/minutes/hours chain and 12-hour display value.
module acc_timekeep (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  logic                           i_cmd,
    input  logic [acc_pkg::CFG_DATA_W-1:0] i_ticks_per_second,
    input  acc_pkg::t_commit               i_commit,
    output acc_pkg::t_view                 o_view
);
    import acc_pkg::*;

    logic [15:0] r_tick, n_tick;
    logic [5:0]  r_sec, n_sec;
    logic [5:0]  r_min, n_min;
    logic [4:0]  r_hour, n_hour;
    logic        r_colon, n_colon;
    logic [16:0] tick_sum;
    logic [4:0]  hour12;
    logic [3:0]  hour_shown;

    assign tick_sum = {1'b0, r_tick} + 17'd1;

    always_comb begin
        n_tick  = r_tick;
        n_sec   = r_sec;
        n_min   = r_min;
        n_hour  = r_hour;
        n_colon = r_colon;
        if (i_fire && (i_cmd == CMD_TICK)) begin
            if (tick_sum >= {1'b0, i_ticks_per_second}) begin
                n_tick  = '0;
                n_colon = !r_colon;
                if (r_sec == SECONDS_MAX) begin
                    n_sec = '0;
                    if (r_min == MINUTES_MAX) begin
                        n_min  = '0;
                        n_hour = (r_hour >= HOURS_MAX) ? '0 : r_hour + 1'b1;
                    end else begin
                        n_min = r_min + 1'b1;
                    end
                end else begin
                    n_sec = r_sec + 1'b1;
                end
            end else begin
                n_tick = tick_sum[15:0];
            end
        end else if (i_commit.valid) begin
            n_hour = i_commit.hours;
            n_min  = i_commit.minutes;
        end
    end

    // midnight and noon show as 12
    assign hour12     = (n_hour >= NOON_HOUR) ? n_hour - NOON_HOUR : n_hour;
    assign hour_shown = (hour12 == '0) ? 4'd12 : hour12[3:0];

    always_comb begin
        o_view.display_value = DISPLAY_W'(hour_shown) * 11'd100 + DISPLAY_W'(n_min);
        o_view.colon_on      = n_colon;
        o_view.is_pm         = (n_hour >= NOON_HOUR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_sec   <= '0;
            r_min   <= '0;
            r_hour  <= '0;
            r_colon <= 1'b0;
        end else begin
            r_tick  <= n_tick;
            r_sec   <= n_sec;
            r_min   <= n_min;
            r_hour  <= n_hour;
            r_colon <= n_colon;
        end
    end

endmodule

FILE: sv/acc_alarm.sv
// Alarm match latch and button debounce that clears the alarm.
module acc_alarm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  logic                           i_cmd,
    input  logic                           i_button,
    input  logic [acc_pkg::DISPLAY_W-1:0]  i_display,
    input  acc_pkg::t_commit               i_commit,
    input  logic [acc_pkg::CFG_DATA_W-1:0] i_debounce_ticks,
    output logic                           o_alarm_active
);
    import acc_pkg::*;

    logic [ALARM_W-1:0] r_alarm_time, n_alarm_time;
    logic               r_sounding, n_sounding;
    logic               r_match_prev, n_match_prev;
    logic               r_raw_prev, n_raw_prev;
    logic               r_debounced, n_debounced;
    logic [15:0]        r_stable, n_stable;
    logic               match;
    logic               armed;

    assign n_alarm_time = (i_fire && i_commit.valid) ? i_commit.alarm_time : r_alarm_time;
    assign match        = (n_alarm_time == ALARM_W'(i_display));
    // latch only on the first request of a match
    assign armed        = r_sounding || (match && !r_match_prev);

    always_comb begin
        n_sounding   = r_sounding;
        n_match_prev = r_match_prev;
        n_raw_prev   = r_raw_prev;
        n_debounced  = r_debounced;
        n_stable     = r_stable;
        if (i_fire) begin
            n_sounding   = armed;
            n_match_prev = match;
            if ((i_cmd == CMD_TICK) && armed) begin
                if (i_button != r_raw_prev) begin
                    n_stable = '0;
                end else if (r_stable != 16'hFFFF) begin
                    n_stable = r_stable + 1'b1;
                end
                if ((n_stable >= i_debounce_ticks) && (i_button != r_debounced)) begin
                    n_debounced = i_button;
                    if (i_button) begin
                        n_sounding = 1'b0;
                    end
                end
                n_raw_prev = i_button;
            end
        end
    end

    assign o_alarm_active = n_sounding;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_time <= '0;
            r_sounding   <= 1'b0;
            r_match_prev <= 1'b0;
            r_raw_prev   <= 1'b0;
            r_debounced  <= 1'b0;
            r_stable     <= '0;
        end else begin
            r_alarm_time <= n_alarm_time;
            r_sounding   <= n_sounding;
            r_match_prev <= n_match_prev;
            r_raw_prev   <= n_raw_prev;
            r_debounced  <= n_debounced;
            r_stable     <= n_stable;
        end
    end

endmodule

FILE: sv/alarm_clock_controller_core.sv
// Top level of the alarm clock controller: request/result registers and config.
//
// Requests arrive on i_req: cmd 0 is one millisecond tick carrying the raw
// button level and pot reading, cmd 1 is a serial character. Every request
// yields exactly one result on o_rsp with the 12-hour HHMM display value,
// colon state, PM flag, alarm flag and buzzer level.
// A request is held in the input register, where the state update and the
// result are formed; the result is then written to the output register, from
// which o_rsp takes it. One request per cycle is sustained while o_rsp takes
// each result: the time, buffer and alarm state close their loop between the
// input and output register.
// When o_rsp stalls, the output register holds its result and the input
// register still takes one more request; i_req.ready then drops until the
// result is taken.
// Synchronous reset clears all time, alarm and buffer-count state, empties
// both registers and loads ticks_per_second = 1000 and debounce_ticks = 50.
// Config writes (i_cfg_we, i_cfg_index, i_cfg_wdata) take effect at once and
// belong in idle periods.
module alarm_clock_controller_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [acc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [acc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    acc_req_if.sink                        i_req,
    acc_rsp_if.source                      o_rsp
);
    import acc_pkg::*;

    logic [CFG_DATA_W-1:0] r_tps;
    logic [CFG_DATA_W-1:0] r_deb;

    logic       r_in_valid;
    logic       r_in_cmd;
    logic       r_in_button;
    logic [9:0] r_in_pot;
    logic [7:0] r_in_char;

    logic                 r_out_valid;
    logic [DISPLAY_W-1:0] r_out_display;
    logic                 r_out_colon;
    logic                 r_out_pm;
    logic                 r_out_alarm;
    logic [7:0]           r_out_buzzer;

    logic    load_in;
    logic    fire;
    logic    alarm_next;
    t_commit commit;
    t_view   view;

    assign fire        = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || fire;
    assign load_in     = i_req.valid && i_req.ready;

    acc_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cmd    (r_in_cmd),
        .i_char   (r_in_char),
        .o_commit (commit)
    );

    acc_timekeep u_timekeep (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (fire),
        .i_cmd              (r_in_cmd),
        .i_ticks_per_second (r_tps),
        .i_commit           (commit),
        .o_view             (view)
    );

    acc_alarm u_alarm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_cmd            (r_in_cmd),
        .i_button         (r_in_button),
        .i_display        (view.display_value),
        .i_commit         (commit),
        .i_debounce_ticks (r_deb),
        .o_alarm_active   (alarm_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
            r_deb <= DEB_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_TPS: r_tps <= i_cfg_wdata;
                CFG_IDX_DEB: r_deb <= i_cfg_wdata;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_in) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in_cmd    <= i_req.cmd;
            r_in_button <= i_req.button_level;
            r_in_pot    <= i_req.pot_level;
            r_in_char   <= i_req.serial_char;
        end
        if (fire) begin
            r_out_display <= view.display_value;
            r_out_colon   <= view.colon_on;
            r_out_pm      <= view.is_pm;
            r_out_alarm   <= alarm_next;
            r_out_buzzer  <= alarm_next ? r_in_pot[9:2] : 8'd0;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.display_value = r_out_display;
    assign o_rsp.colon_on      = r_out_colon;
    assign o_rsp.is_pm         = r_out_pm;
    assign o_rsp.alarm_active  = r_out_alarm;
    assign o_rsp.buzzer_level  = r_out_buzzer;

endmodule

FILE: sv/acc_checker.sv
// Port-level checks for the alarm clock controller, bound to the top level.
module acc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [10:0] i_rsp_display,
    input logic        i_rsp_alarm,
    input logic [7:0]  i_rsp_buzzer
);

    // empty result side always frees the request side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready)
        else $error("request side blocked with empty result register");

    a_buzzer_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_alarm) |-> (i_rsp_buzzer == 8'd0))
        else $error("buzzer driven while alarm is off");

    a_display_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_display >= 11'd100 && i_rsp_display <= 11'd1259))
        else $error("display value out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_display)))
        else $error("stalled result changed");

endmodule

bind alarm_clock_controller_core acc_checker u_acc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_display (o_rsp.display_value),
    .i_rsp_alarm   (o_rsp.alarm_active),
    .i_rsp_buzzer  (o_rsp.buzzer_level)
);
